FILE: src/mexp_pkg.sv
// Shared constants, microcode types and the control store of the modular exponentiation core.
`default_nettype none
package mexp_pkg;

    // Field widths of the external ports
    localparam int MOD_BITS_DEF = 31;
    localparam int BASE_W       = 32;
    localparam int EXP_W        = 31;
    localparam int POWER_W      = 31;
    localparam int CFG_DATA_W   = 31;
    localparam int CFG_IDX_W    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

    // Control store addressing
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_TAKE     = 3'd0;
    localparam t_step ST_RED_BASE = 3'd1;
    localparam t_step ST_BASE_WR  = 3'd2;
    localparam t_step ST_TEST     = 3'd3;
    localparam t_step ST_MUL      = 3'd4;
    localparam t_step ST_MUL_WR   = 3'd5;
    localparam t_step ST_EMIT     = 3'd6;

    // Datapath operation of one step
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TAKE,
        OP_RED_BASE,
        OP_BASE_WR,
        OP_MUL,
        OP_MUL_WR,
        OP_EMIT
    } t_op;

    // Branch condition: true jumps to target; false holds the step, except
    // C_EXP_ZERO, which falls through to the next step.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_WORD,
        C_RED_DONE,
        C_EXP_ZERO,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_word;
        logic red_done;
        logic exp_zero;
        logic out_free;
    } t_seq_status;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        case (step)
            ST_TAKE:     w = '{op: OP_TAKE,     cond: C_IN_WORD,  target: ST_RED_BASE};
            ST_RED_BASE: w = '{op: OP_RED_BASE, cond: C_ALWAYS,   target: ST_BASE_WR};
            ST_BASE_WR:  w = '{op: OP_BASE_WR,  cond: C_RED_DONE, target: ST_TEST};
            ST_TEST:     w = '{op: OP_NONE,     cond: C_EXP_ZERO, target: ST_EMIT};
            ST_MUL:      w = '{op: OP_MUL,      cond: C_ALWAYS,   target: ST_MUL_WR};
            ST_MUL_WR:   w = '{op: OP_MUL_WR,   cond: C_RED_DONE, target: ST_TEST};
            ST_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_FREE, target: ST_TAKE};
            default:     w = '{op: OP_NONE,     cond: C_ALWAYS,   target: ST_TAKE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

FILE: src/mexp_modmul.sv
// Modular multiplier: one registered multiply (or a raw word), then bit-serial restoring remainder.
`default_nettype none
module mexp_modmul
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic                i_load_raw,
    input  wire logic [BASE_W-1:0]   i_raw,
    input  wire logic [MOD_BITS-1:0] i_a,
    input  wire logic [MOD_BITS-1:0] i_b,
    input  wire logic [MOD_BITS-1:0] i_m,
    output logic                     o_done,
    output logic [MOD_BITS-1:0]      o_rem
);

    localparam int DW    = (2 * MOD_BITS > BASE_W) ? 2 * MOD_BITS : BASE_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]         r_div;
    logic [MOD_BITS-1:0]   r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [2*MOD_BITS-1:0] w_prod;
    logic [MOD_BITS:0]     w_shift;
    logic [MOD_BITS:0]     w_sub;
    logic                  w_ge;
    logic [MOD_BITS-1:0]   n_rem;

    assign w_prod  = {{MOD_BITS{1'b0}}, i_a} * {{MOD_BITS{1'b0}}, i_b};
    // bring in the next dividend bit, subtract the modulus when it fits
    assign w_shift = {r_rem, r_div[DW-1]};
    assign w_sub   = w_shift - {1'b0, i_m};
    assign w_ge    = w_shift >= {1'b0, i_m};
    assign n_rem   = w_ge ? w_sub[MOD_BITS-1:0] : w_shift[MOD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_load_raw ? DW'(i_raw) : DW'(w_prod);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_div <= r_div << 1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

FILE: src/mexp_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none
module mexp_seq
    import mexp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_seq_status i_status,
    output t_uword           o_uword
);

    t_step  r_pc;
    t_step  n_pc;
    t_uword w_uword;

    assign w_uword = ucode(r_pc);

    always_comb begin
        n_pc = r_pc;
        case (w_uword.cond)
            C_ALWAYS:   n_pc = w_uword.target;
            C_IN_WORD:  n_pc = i_status.in_word  ? w_uword.target : r_pc;
            C_RED_DONE: n_pc = i_status.red_done ? w_uword.target : r_pc;
            C_EXP_ZERO: n_pc = i_status.exp_zero ? w_uword.target : r_pc + t_step'(1);
            C_OUT_FREE: n_pc = i_status.out_free ? w_uword.target : r_pc;
            default:    n_pc = ST_TAKE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_TAKE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = w_uword;

endmodule
`default_nettype wire

FILE: src/modular_exponentiation_core.sv
// Top level of the modular exponentiation core: registers, datapath and sequencer.
//
//  channel  direction  handshake                   word carries
//  -------  ---------  --------------------------  ------------------------------
//  in       sink       i_in_valid / o_in_ready     i_base (32 b)
//  out      source     o_out_valid / i_out_ready   o_power (31 b)
//  cfg      sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data (31 b)
//
//  Each word costs one pass of the bit-serial remainder units (one dividend bit per
//  cycle, DW = max(2*MOD_BITS, 32) dividend bits per pass) for the base reduction
//  and one pass for each exponent bit.
//  The result multiply and the base square of one step run in two lanes side by side.
//  Reset is synchronous: modulus returns to 1, exponent to 0, the sequencer to its
//  input step and the output register to empty. A stalled result sits in the output
//  register while the next input word is taken; cfg is always ready.
`default_nettype none
module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [BASE_W-1:0]     i_base,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [POWER_W-1:0]         o_power,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [MOD_BITS-1:0] r_mod;
    logic [EXP_W-1:0]    r_exp;

    // working registers of one word
    logic [BASE_W-1:0]   r_base;
    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] r_b;
    logic [EXP_W-1:0]    r_e;

    // output register
    logic                r_out_valid;
    logic [POWER_W-1:0]  r_power;

    logic [MOD_BITS-1:0] w_m;
    logic                w_in_word;
    logic                w_out_free;
    logic                w_done0;
    logic                w_done1;
    logic [MOD_BITS-1:0] w_rem0;
    logic [MOD_BITS-1:0] w_rem1;
    logic                w_start0;
    logic                w_start1;
    t_uword              w_uword;
    t_seq_status         w_status;

    // a zero modulus behaves as a modulus of one
    assign w_m = (r_mod == '0) ? MOD_BITS'(1) : r_mod;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (w_uword.op == OP_TAKE);
    assign w_in_word   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign w_status = '{
        in_word:  w_in_word,
        red_done: w_done0,
        exp_zero: (r_e == '0),
        out_free: w_out_free
    };

    mexp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_uword  (w_uword)
    );

    // lane 0 reduces the base, then forms acc * b; lane 1 forms b * b
    assign w_start0 = (w_uword.op == OP_RED_BASE) || (w_uword.op == OP_MUL);
    assign w_start1 = (w_uword.op == OP_MUL);

    mexp_modmul #(.MOD_BITS(MOD_BITS)) u_lane0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start0),
        .i_load_raw (w_uword.op == OP_RED_BASE),
        .i_raw      (r_base),
        .i_a        (r_acc),
        .i_b        (r_b),
        .i_m        (w_m),
        .o_done     (w_done0),
        .o_rem      (w_rem0)
    );

    mexp_modmul #(.MOD_BITS(MOD_BITS)) u_lane1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start1),
        .i_load_raw (1'b0),
        .i_raw      ('0),
        .i_a        (r_b),
        .i_b        (r_b),
        .i_m        (w_m),
        .o_done     (w_done1),
        .o_rem      (w_rem1)
    );

    // configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_BITS'(1);
            r_exp <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODULUS:  r_mod <= i_cfg_data[MOD_BITS-1:0];
                REG_EXPONENT: r_exp <= i_cfg_data[EXP_W-1:0];
                default:      ;
            endcase
        end
    end

    // working registers advance under the current micro-op
    always_ff @(posedge i_clk) begin
        if (w_in_word) begin
            r_base <= i_base;
            r_acc  <= MOD_BITS'(1);
            r_e    <= r_exp;
        end
        if ((w_uword.op == OP_BASE_WR) && w_done0) begin
            r_b <= w_rem0;
        end
        if ((w_uword.op == OP_MUL_WR) && w_done0) begin
            if (r_e[0]) begin
                r_acc <= w_rem0;
            end
            r_b <= w_rem1;
            r_e <= r_e >> 1;
        end
    end

    // output register: hold until taken, load on the emit step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_uword.op == OP_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_uword.op == OP_EMIT) && w_out_free) begin
            r_power <= POWER_W'(r_acc);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_power     = r_power;

    // the emit step loads the output register whenever it has room
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_uword.op == OP_EMIT) && w_out_free) |=> r_out_valid)
        else $error("emit step did not load the output register");

    // a result leaves only once every exponent bit is consumed
    a_emit_exp_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uword.op == OP_EMIT) |-> (r_e == '0))
        else $error("emit step reached with exponent bits left");

    // the square lane never finishes apart from the product lane
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done1 |-> w_done0)
        else $error("square lane finished without the product lane");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the modular exponentiation core: directed table, then random phases.
`default_nettype none
module testbench;
    import mexp_pkg::*;

    localparam int MOD_BITS = MOD_BITS_DEF;

    // Indexes past the last register; writes to them must leave the core untouched
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam logic [CFG_DATA_W-1:0] MOD_MASK = {CFG_DATA_W{1'b1}} >> (CFG_DATA_W - MOD_BITS);

    localparam int RANDOM_ITEMS = 265;
    localparam int QUIET_FROM   = RANDOM_ITEMS - 30;  // no idling on either side past this
    // Drain for longer than one worst-case word after the last result
    localparam int DRAIN_CYCLES = 2500;
    // Cycle budget for the whole run, words and stalls included
    localparam int CYCLE_LIMIT  = 4_000_000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [BASE_W-1:0]     i_base      = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    wire logic             o_in_ready;
    wire logic             o_out_valid;
    wire logic [POWER_W-1:0] o_power;
    wire logic             o_cfg_ready;

    modular_exponentiation_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_base      (i_base),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_power     (o_power),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the two registers, as the core holds them after reset
    logic [CFG_DATA_W-1:0] modulus_cfg  = 31'd1;
    logic [EXP_W-1:0]      exponent_cfg = '0;

    // Powers still owed by the core, oldest first
    logic [POWER_W-1:0] pending_powers [$];

    int          mismatches  = 0;
    int          cycle_count = 0;
    int unsigned in_gap_odds = 0;  // 1 in N chance of a gap before a word; 0 turns gaps off
    int unsigned ready_odds  = 0;  // same for stalls on the result side
    int unsigned ready_hold  = 0;

    // Square and multiply from the low exponent bit up, every product reduced.
    // A modulus of zero acts as one; exponent zero leaves the result at 1, unreduced.
    function automatic logic [POWER_W-1:0] mod_power(input logic [BASE_W-1:0] base_in);
        logic [63:0]      n;
        logic [63:0]      sq;
        logic [63:0]      acc;
        logic [EXP_W-1:0] e;
        n   = (modulus_cfg == '0) ? 64'd1 : 64'(modulus_cfg);
        sq  = 64'(base_in) % n;
        acc = 64'd1;
        e   = exponent_cfg;
        while (e != '0) begin
            if (e[0]) begin
                acc = (acc * sq) % n;
            end
            e  = e >> 1;
            sq = (sq * sq) % n;
        end
        return acc[POWER_W-1:0];
    endfunction

    // Present one base word, maybe after a gap, and hold it until taken.
    // Call at a rising edge; returns at the edge that accepts the word.
    task automatic push_base(input logic [BASE_W-1:0] base_in,
                             input logic [POWER_W-1:0] power_due);
        if (i_cfg_valid) begin
            i_cfg_valid <= 1'b0;
        end
        if (in_gap_odds != 0 && $urandom_range(0, in_gap_odds - 1) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_base     <= base_in;
        do @(posedge i_clk); while (!o_in_ready);
        pending_powers.push_back(power_due);
    endtask

    // Drain the core, then write one register; out-of-range indexes change nothing.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
        end
        while (pending_powers.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MODULUS:  modulus_cfg  = data & MOD_MASK;
            REG_EXPONENT: exponent_cfg = data;
            default: ;
        endcase
    endtask

    // Directed table. Known rows carry a power readable straight off the math;
    // plain base rows go through the predictor. The index is unused on base rows.
    typedef enum logic [1:0] {
        ROW_REG,
        ROW_BASE,
        ROW_BASE_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [31:0]           value;  // register data or base word
        logic [POWER_W-1:0]    power;
    } t_row;

    localparam int NUM_ROWS = 35;

    t_row plan [NUM_ROWS] = '{
        // reset values: modulus 1, exponent 0, so everything gives 1
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'h0000_0000, 31'd1},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'hFFFF_FFFF, 31'd1},
        // writes past the register map are dropped
        '{ROW_REG,        REG_SPARE_LO, 32'h7FFF_FFFF, 31'd0},
        '{ROW_REG,        REG_SPARE_HI, 32'h2AAA_AAAA, 31'd0},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'h0000_0007, 31'd1},
        // modulus 1 reduces everything to 0 once the exponent is nonzero
        '{ROW_REG,        REG_EXPONENT, 32'h0000_0001, 31'd0},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'h0000_3039, 31'd0},
        // modulus 0 behaves as modulus 1
        '{ROW_REG,        REG_MODULUS,  32'h0000_0000, 31'd0},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'h0000_0063, 31'd0},
        '{ROW_REG,        REG_EXPONENT, 32'h0000_0000, 31'd0},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'h0000_0063, 31'd1},
        // largest modulus
        '{ROW_REG,        REG_MODULUS,  32'h7FFF_FFFF, 31'd0},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'hFFFF_FFFF, 31'd1},
        '{ROW_REG,        REG_EXPONENT, 32'h0000_0001, 31'd0},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'hFFFF_FFFF, 31'd1},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'h1234_5678, 31'h1234_5678},
        // largest exponent: every bit set, longest run through the core
        '{ROW_REG,        REG_EXPONENT, 32'h7FFF_FFFF, 31'd0},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'h0000_0000, 31'd0},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'h0000_0001, 31'd1},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'h7FFF_FFFF, 31'd0},
        '{ROW_BASE,       REG_MODULUS,  32'hFFFF_FFFE, 31'd0},
        '{ROW_BASE,       REG_MODULUS,  32'hDEAD_BEEF, 31'd0},
        // only the top exponent bit set
        '{ROW_REG,        REG_EXPONENT, 32'h4000_0000, 31'd0},
        '{ROW_REG,        REG_MODULUS,  32'h0000_000D, 31'd0},
        '{ROW_BASE,       REG_MODULUS,  32'h0000_0002, 31'd0},
        '{ROW_REG,        REG_MODULUS,  32'h0000_0002, 31'd0},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'h0000_0003, 31'd1},
        // alternating bit patterns in exponent and base, a 5A pattern in the modulus
        '{ROW_REG,        REG_EXPONENT, 32'h5555_5555, 31'd0},
        '{ROW_REG,        REG_MODULUS,  32'h5A5A_5A5A, 31'd0},
        '{ROW_BASE,       REG_MODULUS,  32'hAAAA_AAAA, 31'd0},
        // textbook key pair n = 61 * 53: encrypt 65, then decrypt it back
        '{ROW_REG,        REG_MODULUS,  32'd3233,      31'd0},
        '{ROW_REG,        REG_EXPONENT, 32'd17,        31'd0},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'd65,        31'd2790},
        '{ROW_REG,        REG_EXPONENT, 32'd2753,      31'd0},
        '{ROW_BASE_KNOWN, REG_MODULUS,  32'd2790,      31'd65}
    };

    // Result side: check each word taken against the oldest owed power,
    // then pick ready for the next edge, stalling in random bursts.
    always @(posedge i_clk) begin : result_side
        logic [POWER_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_powers.size() == 0) begin
                $display("%0t: power word %0d with none owed", $time, o_power);
                mismatches++;
            end else begin
                want = pending_powers.pop_front();
                if (o_power !== want) begin
                    $display("%0t: power mismatch, expected %0d, got %0d",
                             $time, want, o_power);
                    mismatches++;
                end
            end
        end
        if (ready_hold != 0) begin
            ready_hold--;
            i_out_ready <= 1'b0;
        end else if (ready_odds != 0 && $urandom_range(0, ready_odds - 1) == 0) begin
            ready_hold = $urandom_range(0, 13);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned       sent;
        int unsigned       bits;
        logic [BASE_W-1:0] base_word;
        logic [CFG_DATA_W-1:0] reg_word;

        // Hold reset, then release it
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table with moderate idling on both sides
        in_gap_odds = 3;
        ready_odds  = 4;
        foreach (plan[r]) begin
            case (plan[r].kind)
                ROW_REG:        write_reg(plan[r].idx, plan[r].value[CFG_DATA_W-1:0]);
                ROW_BASE:       push_base(plan[r].value, mod_power(plan[r].value));
                ROW_BASE_KNOWN: push_base(plan[r].value, plan[r].power);
                default: ;
            endcase
        end

        // Random phases: new settings while drained, then a run of base words
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent < QUIET_FROM) begin
                case ($urandom_range(0, 2))
                    0:       in_gap_odds = 0;
                    1:       in_gap_odds = 2;
                    default: in_gap_odds = 6;
                endcase
                case ($urandom_range(0, 2))
                    0:       ready_odds = 0;
                    1:       ready_odds = 3;
                    default: ready_odds = 25;
                endcase
            end

            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       reg_word = 31'd1;
                    1:       reg_word = 31'd0;
                    2:       reg_word = 31'd2;
                    3:       reg_word = 31'h7FFF_FFFF;
                    4, 5:    reg_word = CFG_DATA_W'($urandom_range(3, 1000));
                    default: reg_word = CFG_DATA_W'($urandom);
                endcase
                write_reg(REG_MODULUS, reg_word);
            end

            // Keep most exponents short so the run stays quick; a few use all 31 bits
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 19))
                    0:       reg_word = '0;
                    1:       reg_word = {1'b1, 30'($urandom)};
                    2:       reg_word = 31'h7FFF_FFFF;
                    default: begin
                        bits     = $urandom_range(1, 8);
                        reg_word = CFG_DATA_W'(($urandom & ((1 << bits) - 1)) | (1 << (bits - 1)));
                    end
                endcase
                write_reg(REG_EXPONENT, reg_word);
            end

            if ($urandom_range(0, 5) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          CFG_DATA_W'($urandom));
            end

            repeat ($urandom_range(4, 24)) begin
                if (sent >= QUIET_FROM) begin
                    in_gap_odds = 0;
                    ready_odds  = 0;
                end
                case ($urandom_range(0, 15))
                    0:       base_word = '0;
                    1:       base_word = '1;
                    2:       base_word = BASE_W'(modulus_cfg);
                    3:       base_word = BASE_W'(modulus_cfg) - 1'b1;
                    default: base_word = $urandom;
                endcase
                push_base(base_word, mod_power(base_word));
                sent++;
            end
        end

        // Drop valids, wait out every owed power, then watch for strays
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
        end
        if (i_cfg_valid) begin
            i_cfg_valid <= 1'b0;
        end
        while (pending_powers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
src/mexp_pkg.sv
src/mexp_modmul.sv
src/mexp_seq.sv
src/modular_exponentiation_core.sv
sim/testbench.sv
